[rtl/pee_pkg.sv]
// shared types, codes and constants of the postfix expression evaluator
// used by pee_front, pee_div, pee_back and postfix_expression_evaluator_top
`default_nettype none

package pee_pkg;

    // default operand stack depth
    localparam int STACK_DEPTH_DEF = 64;

    // front-to-back queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // characters of interest
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    // classified operation
    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_DROP,
        OP_NOP
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_DIVZ  = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    // execution sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_OPER,
        S_MUL,
        S_DIV,
        S_TAIL,
        S_EMIT
    } t_state;

    // one classified beat in the queue
    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        logic       last;
    } t_item;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[rtl/pee_front.sv]
// front end: accepts character beats, classifies them and queues them
// depends on pee_pkg
`default_nettype none

module pee_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_symbol,
    input  wire logic           i_last,
    input  wire logic           i_push,
    output logic                o_full,
    output pee_pkg::t_item      o_item,
    output logic                o_valid,
    input  wire logic           i_take
);
    import pee_pkg::*;

    t_item            r_slot [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [Q_CW-1:0]  r_count;
    logic             is_space;
    logic             accept;
    logic             enq;
    logic             deq;
    t_item            cls;

    // classify the incoming character
    always_comb begin
        is_space  = (i_symbol == CHAR_SPACE) || (i_symbol >= CHAR_TAB && i_symbol <= CHAR_CR);
        cls.last  = i_last;
        cls.digit = 4'(i_symbol - CHAR_ZERO);
        if (is_space) begin
            cls.op = OP_NOP;
        end else if (i_symbol >= CHAR_ZERO && i_symbol <= CHAR_NINE) begin
            cls.op = OP_PUSH;
        end else if (i_symbol == CHAR_PLUS) begin
            cls.op = OP_ADD;
        end else if (i_symbol == CHAR_MINUS) begin
            cls.op = OP_SUB;
        end else if (i_symbol == CHAR_STAR) begin
            cls.op = OP_MUL;
        end else if (i_symbol == CHAR_SLASH) begin
            cls.op = OP_DIV;
        end else begin
            cls.op = OP_DROP;
        end
    end

    // queue control; plain whitespace is accepted and dropped
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign accept  = i_push && !o_full;
    assign enq     = accept && (!is_space || i_last);
    assign deq     = i_take && o_valid;
    assign o_item  = r_slot[r_rptr];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (enq) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (deq) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (enq && !deq) begin
                r_count <= r_count + 1'b1;
            end else if (deq && !enq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slot[r_wptr] <= cls;
        end
    end

endmodule

`default_nettype wire

[rtl/pee_div.sv]
// iterative signed 32-bit divider, one quotient bit per cycle, truncating
// depends on pee_pkg
`default_nettype none

module pee_div (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire pee_pkg::t_div_req i_req,
    output pee_pkg::t_div_rsp o_rsp
);
    import pee_pkg::*;

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic        r_neg;
    logic [4:0]  r_step;
    logic        r_busy;
    logic        r_fin;
    logic [32:0] shifted;
    logic [33:0] diff;
    logic        qbit;

    // one restoring step
    always_comb begin
        shifted = {r_rem, r_quo[31]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        qbit    = !diff[33];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_step <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // datapath on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend[31] ? -i_req.dividend : i_req.dividend;
            r_div <= i_req.divisor[31] ? -i_req.divisor : i_req.divisor;
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
        end else if (r_busy) begin
            r_rem <= qbit ? diff[31:0] : shifted[31:0];
            r_quo <= {r_quo[30:0], qbit};
        end
    end

    // apply the sign on the way out
    assign o_rsp.done = r_fin;
    assign o_rsp.quot = r_neg ? -r_quo : r_quo;

endmodule

`default_nettype wire

[rtl/pee_back.sv]
// back end: operand stack, execution sequencer and result register
// depends on pee_pkg and pee_div
`default_nettype none

module pee_back #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pee_pkg::t_item i_item,
    input  wire logic          i_valid,
    output logic               o_take,
    output logic               o_out_valid,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status,
    input  wire logic          i_pop
);
    import pee_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // stack memory and read registers
    logic [31:0]   r_stack [STACK_DEPTH];
    logic [31:0]   r_rhs;
    logic [31:0]   r_lhs;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    t_status       r_status;
    t_status       n_status;
    t_op           r_op;
    logic          r_last;
    logic [31:0]   r_prod;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [31:0]   r_value;
    logic [31:0]   n_value;
    t_status       r_out_status;
    t_status       n_out_status;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          active;
    logic          out_free;
    logic          to_oper;
    logic [31:0]   sum;
    logic [31:0]   dif;
    t_div_req      div_req;
    t_div_rsp      div_rsp;

    pee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // shared helpers
    assign cnt_m1   = r_cnt - CW'(1);
    assign cnt_m2   = r_cnt - CW'(2);
    assign active   = (r_status == ST_OK) && (i_item.op != OP_NOP);
    assign out_free = !r_out_valid || i_pop;
    assign to_oper  = i_valid && active && (i_item.op != OP_PUSH) && (r_cnt >= CW'(2));
    assign sum      = r_lhs + r_rhs;
    assign dif      = r_lhs - r_rhs;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (to_oper) begin
                    n_state = S_OPER;
                end else if (i_valid && i_item.last) begin
                    n_state = S_TAIL;
                end
            end
            S_OPER: begin
                if (r_op == OP_MUL) begin
                    n_state = S_MUL;
                end else if (r_op == OP_DIV && r_rhs != '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = r_last ? S_TAIL : S_IDLE;
                end
            end
            S_MUL: begin
                n_state = r_last ? S_TAIL : S_IDLE;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = r_last ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_take           = 1'b0;
        we               = 1'b0;
        waddr            = r_cnt[AW-1:0];
        wdata            = '0;
        n_cnt            = r_cnt;
        n_status         = r_status;
        n_out_valid      = r_out_valid && !i_pop;
        n_value          = r_value;
        n_out_status     = r_out_status;
        div_req.start    = 1'b0;
        div_req.dividend = r_lhs;
        div_req.divisor  = r_rhs;
        unique case (r_state)
            S_IDLE: begin
                o_take = i_valid;
                if (i_valid && active) begin
                    if (i_item.op == OP_PUSH) begin
                        if (r_cnt >= CW'(STACK_DEPTH)) begin
                            n_status = ST_OVER;
                        end else begin
                            we    = 1'b1;
                            wdata = {28'd0, i_item.digit};
                            n_cnt = r_cnt + CW'(1);
                        end
                    end else if (r_cnt < CW'(2)) begin
                        n_status = ST_UNDER;
                    end
                end
            end
            S_OPER: begin
                waddr = cnt_m2[AW-1:0];
                n_cnt = cnt_m2;
                case (r_op)
                    OP_ADD: begin
                        we    = 1'b1;
                        wdata = sum;
                        n_cnt = cnt_m1;
                    end
                    OP_SUB: begin
                        we    = 1'b1;
                        wdata = dif;
                        n_cnt = cnt_m1;
                    end
                    OP_DIV: begin
                        if (r_rhs == '0) begin
                            n_status = ST_DIVZ;
                        end else begin
                            div_req.start = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                we    = 1'b1;
                wdata = r_prod;
                n_cnt = r_cnt + CW'(1);
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    we    = 1'b1;
                    wdata = div_rsp.quot;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_TAIL: begin
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_cnt       = '0;
                    n_status    = ST_OK;
                    if (r_status != ST_OK) begin
                        n_value      = '0;
                        n_out_status = r_status;
                    end else if (r_cnt == '0) begin
                        n_value      = '0;
                        n_out_status = ST_UNDER;
                    end else begin
                        n_value      = r_rhs;
                        n_out_status = ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_op   <= i_item.op;
            r_last <= i_item.last;
        end
        r_prod       <= r_lhs * r_rhs;
        r_value      <= n_value;
        r_out_status <= n_out_status;
    end

    // stack memory: one write port, two registered read ports at the top
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_stack[waddr] <= wdata;
        end
        r_rhs <= r_stack[cnt_m1[AW-1:0]];
        r_lhs <= r_stack[cnt_m2[AW-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

[rtl/postfix_expression_evaluator_top.sv]
// postfix expression evaluator: a two-beat input queue decouples the classifier
// from the stack sequencer. Per character in the sequencer: a digit is pushed in
// idle, + - and other symbols pass the operate state, * also the multiply state,
// / also waits in the divide state (one quotient bit per cycle); the last beat
// then passes the tail and emit states. Synchronous active-low reset empties the
// queue and result register and clears count and status, not stack contents.
`default_nettype none

module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_symbol,
    input  wire logic          i_last,
    input  wire logic          push,
    output logic               full,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status,
    output logic               empty,
    input  wire logic          pop
);
    import pee_pkg::*;

    t_item item;
    logic  item_valid;
    logic  item_take;
    logic  out_valid;

    // front end
    pee_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_symbol (i_symbol),
        .i_last   (i_last),
        .i_push   (push),
        .o_full   (full),
        .o_item   (item),
        .o_valid  (item_valid),
        .i_take   (item_take)
    );

    // back end
    pee_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_valid     (item_valid),
        .o_take      (item_take),
        .o_out_valid (out_valid),
        .o_value     (o_value),
        .o_status    (o_status),
        .i_pop       (pop)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire
